// ===== rtl/isd_pkg.sv =====
// Shared types and constants for the IMU stationary detector.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package isd_pkg;

  localparam int AXES        = 6;
  localparam int GYRO_AXES   = 3;
  localparam int SAMPLE_W    = 16;
  localparam int BLOCK_SUM_W = 24;  // holds 255 full-scale samples
  localparam int SUM_W       = 32;
  localparam int LIMIT_W     = 15;
  localparam int WINDOW_W    = 16;
  localparam int TIME_W      = 32;
  localparam int RECIP_W     = 25;  // ceil(2^(24+clog2(d))/d) fits 25 bits
  localparam int MEAN_Q_W    = 17;  // magnitude of a mean, up to 32768
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_WINDOW = 2'd2;

  localparam logic [LIMIT_W-1:0]  GYRO_LIMIT_RST   = 15'd100;
  localparam logic [LIMIT_W-1:0]  ACCEL_LIMIT_RST  = 15'd100;
  localparam logic [WINDOW_W-1:0] STILL_WINDOW_RST = 16'd833;

  // controls broadcast from the control unit to every axis lane
  typedef struct packed {
    logic accept;        // beat taken at the input this cycle
    logic block_done;    // that beat closes an averaging block
    logic advance;       // stage 1 moves into stage 2
    logic commit;        // stage 2 updates state and loads the output
    logic commit_block;  // the committing beat closed a block
    logic motion;        // some axis left its band
    logic period_end;    // the committing beat completes a still period
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/isd_lane.sv =====
// One axis lane: block average with reciprocal divide, reference compare
// and still-period sum. Depends on isd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isd_lane
  import isd_pkg::*;
#(
  parameter int AVERAGE_BLOCK = 125
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire lane_ctl_t             ctl,
  input  wire        [LIMIT_W-1:0]   limit,
  input  wire signed [SAMPLE_W-1:0]  sample,
  output logic                       in_band,
  output logic       [SUM_W-1:0]     sum_after
);

  // exact truncating divide by reciprocal for magnitudes below 2^24
  localparam int          RECIP_SHIFT = BLOCK_SUM_W + $clog2(AVERAGE_BLOCK);
  localparam logic [63:0] RECIP_FULL  =
    ((64'd1 << RECIP_SHIFT) + 64'(AVERAGE_BLOCK) - 64'd1) / 64'(AVERAGE_BLOCK);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int          PROD_W      = BLOCK_SUM_W + RECIP_W;

  logic signed [BLOCK_SUM_W-1:0] block_sum;
  logic signed [BLOCK_SUM_W-1:0] block_total;
  logic        [BLOCK_SUM_W-1:0] total_mag;
  logic        [BLOCK_SUM_W-1:0] mag1;
  logic                          neg1;
  logic                          neg2;
  logic        [PROD_W-1:0]      prod_c;
  logic        [PROD_W-1:0]      prod2;
  logic        [MEAN_Q_W-1:0]    quot;
  logic        [MEAN_Q_W-1:0]    quot_neg;
  logic        [SAMPLE_W-1:0]    mean_new;
  logic        [SAMPLE_W-1:0]    mean_now;
  logic        [SAMPLE_W-1:0]    block_mean;
  logic        [SAMPLE_W-1:0]    reference;
  logic signed [SAMPLE_W-1:0]    s1;
  logic signed [SAMPLE_W-1:0]    s2;
  logic        [SAMPLE_W-1:0]    diff;
  logic signed [SAMPLE_W:0]      diff_x;
  logic signed [SAMPLE_W:0]      lim_x;
  logic        [SUM_W-1:0]       still_sum;

  assign block_total = block_sum + {{(BLOCK_SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
  assign total_mag   = block_total[BLOCK_SUM_W-1] ? (~block_total + 1'b1) : block_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum <= '0;
    end else if (ctl.accept) begin
      block_sum <= ctl.block_done ? '0 : block_total;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1   <= sample;
      mag1 <= total_mag;
      neg1 <= block_total[BLOCK_SUM_W-1];
    end
    if (ctl.advance) begin
      s2    <= s1;
      prod2 <= prod_c;
      neg2  <= neg1;
    end
  end

  assign prod_c   = mag1 * RECIP;
  assign quot     = prod2[RECIP_SHIFT +: MEAN_Q_W];
  assign quot_neg = ~quot + 1'b1;
  assign mean_new = neg2 ? quot_neg[SAMPLE_W-1:0] : quot[SAMPLE_W-1:0];
  assign mean_now = ctl.commit_block ? mean_new : block_mean;

  // difference wraps to 16 bits, must lie strictly inside +/- limit
  assign diff    = s2 - reference;
  assign diff_x  = {diff[SAMPLE_W-1], diff};
  assign lim_x   = {2'b00, limit};
  assign in_band = (diff_x < lim_x) && (diff_x > -lim_x);

  assign sum_after = still_sum + {{(SUM_W-SAMPLE_W){s2[SAMPLE_W-1]}}, s2};

  always_ff @(posedge clk) begin
    if (rst) begin
      block_mean <= '0;
      reference  <= '0;
      still_sum  <= '0;
    end else if (ctl.commit) begin
      if (ctl.commit_block) begin
        block_mean <= mean_new;
      end
      if (ctl.motion) begin
        reference <= mean_now;
        still_sum <= '0;
      end else if (ctl.period_end) begin
        still_sum <= '0;
      end else begin
        still_sum <= sum_after;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/isd_ctrl.sv =====
// Control and merge unit: handshakes, config registers, block fill,
// still count, flag and window timing, and the result register.
// Depends on isd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isd_ctrl
  import isd_pkg::*;
#(
  parameter int AVERAGE_BLOCK = 125
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire        [TIME_W-1:0]        now_us,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire        [CFG_IDX_W-1:0]     cfg_index,
  input  wire        [CFG_DATA_W-1:0]    cfg_data,
  output logic       [LIMIT_W-1:0]       gyro_limit,
  output logic       [LIMIT_W-1:0]       accel_limit,
  input  wire        [AXES-1:0]          lane_inside,
  input  wire        [AXES-1:0][SUM_W-1:0] lane_sums,
  output lane_ctl_t                      ctl,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           is_still,
  output logic                           period_done,
  output logic       [AXES-1:0][SUM_W-1:0] totals,
  output logic       [WINDOW_W-1:0]      period_samples,
  output logic       [TIME_W-1:0]        period_elapsed_us
);

  localparam int FILL_W = $clog2(AVERAGE_BLOCK + 1);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(AVERAGE_BLOCK - 1);

  logic                v1;
  logic                v2;
  logic                adv_out;
  logic                adv2;
  logic                in_fire;
  logic                move12;
  logic                commit;
  logic [FILL_W-1:0]   fill;
  logic                done0;
  logic                done1;
  logic                done2;
  logic [TIME_W-1:0]   now1;
  logic [TIME_W-1:0]   now2;
  logic [WINDOW_W-1:0] still_window;
  logic [WINDOW_W-1:0] still_count;
  logic [WINDOW_W-1:0] count_inc;
  logic [TIME_W-1:0]   window_start;
  logic                still_flag;
  logic                motion;
  logic                period_end;

  // stage advance, from the output back to the input
  assign adv_out  = !out_valid || !out_stall;
  assign adv2     = !v2 || adv_out;
  assign in_stall = v1 && !adv2;
  assign in_fire  = in_valid && !in_stall;
  assign move12   = v1 && adv2;
  assign commit   = v2 && adv_out;

  assign done0      = (fill == FILL_LAST);
  assign motion     = !(&lane_inside);
  assign count_inc  = still_count + 1'b1;
  assign period_end = !motion && (count_inc >= still_window);

  assign ctl.accept       = in_fire;
  assign ctl.block_done   = done0;
  assign ctl.advance      = move12;
  assign ctl.commit       = commit;
  assign ctl.commit_block = done2;
  assign ctl.motion       = motion;
  assign ctl.period_end   = period_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_limit   <= GYRO_LIMIT_RST;
      accel_limit  <= ACCEL_LIMIT_RST;
      still_window <= STILL_WINDOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GYRO_LIMIT:   gyro_limit   <= cfg_data[LIMIT_W-1:0];
        REG_ACCEL_LIMIT:  accel_limit  <= cfg_data[LIMIT_W-1:0];
        REG_STILL_WINDOW: still_window <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      fill      <= '0;
    end else begin
      if (in_fire) begin
        v1   <= 1'b1;
        fill <= done0 ? '0 : fill + 1'b1;
      end else if (move12) begin
        v1 <= 1'b0;
      end
      if (move12) begin
        v2 <= 1'b1;
      end else if (commit) begin
        v2 <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now1  <= now_us;
      done1 <= done0;
    end
    if (move12) begin
      now2  <= now1;
      done2 <= done1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      still_count  <= '0;
      window_start <= '0;
      still_flag   <= 1'b0;
    end else if (commit) begin
      if (motion) begin
        still_flag   <= 1'b0;
        still_count  <= '0;
        window_start <= now2;
      end else if (period_end) begin
        still_flag   <= 1'b1;
        still_count  <= '0;
        window_start <= now2;
      end else begin
        still_count <= count_inc;
      end
    end
  end

  // result register; the period fields read zero unless a period closes
  always_ff @(posedge clk) begin
    if (commit) begin
      is_still          <= !motion && (period_end || still_flag);
      period_done       <= period_end;
      totals            <= period_end ? lane_sums : '0;
      period_samples    <= period_end ? count_inc : '0;
      period_elapsed_us <= period_end ? (now2 - window_start) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imu_stationary_detector_core.sv =====
// IMU stationary detector top level: six axis lanes and the control unit.
// Depends on isd_pkg, isd_lane and isd_ctrl.
//
// Usage notes
//  - Input channel: one beat per IMU sample (three gyro axes, three accel
//    axes, signed 16 bit, plus a microsecond timestamp). A beat is taken
//    at a rising edge with in_valid high and in_stall low.
//  - Output channel: exactly one result beat per input beat, in order,
//    taken at an edge with out_valid high and out_stall low.
//  - Config channel: cfg_ready is always high; index 0 gyro limit, 1 accel
//    limit, 2 still window. Other indexes are dropped. Write only when idle.
//  - Pipeline: three register stages (sample/block add, reciprocal multiply,
//    compare/merge) lie between the accepting edge and out_valid rising.
//  - Throughput: one sample per clock, sustained while out_stall stays low,
//    set by the per-lane compare and accumulate in the last stage.
//  - Stall: the stages fill bubbles first; in_stall rises only when all
//    three stages hold beats and the output is stalled.
//  - Reset (rst, synchronous): pipeline empties, limits return to 100/100,
//    window to 833, all averages, references and sums clear, not stationary.
`timescale 1ns / 1ps
`default_nettype none

module imu_stationary_detector_core
  import isd_pkg::*;
#(
  parameter int AVERAGE_BLOCK = 125
) (
  input  wire                        clk,
  input  wire                        rst,
  // sample channel
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire signed [SAMPLE_W-1:0]  gyro_x,
  input  wire signed [SAMPLE_W-1:0]  gyro_y,
  input  wire signed [SAMPLE_W-1:0]  gyro_z,
  input  wire signed [SAMPLE_W-1:0]  accel_x,
  input  wire signed [SAMPLE_W-1:0]  accel_y,
  input  wire signed [SAMPLE_W-1:0]  accel_z,
  input  wire        [TIME_W-1:0]    now_us,
  // config channel
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire        [CFG_IDX_W-1:0] cfg_index,
  input  wire        [CFG_DATA_W-1:0] cfg_data,
  // result channel
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic                       is_still,
  output logic                       period_done,
  output logic signed [SUM_W-1:0]    gyro_total_x,
  output logic signed [SUM_W-1:0]    gyro_total_y,
  output logic signed [SUM_W-1:0]    gyro_total_z,
  output logic signed [SUM_W-1:0]    accel_total_x,
  output logic signed [SUM_W-1:0]    accel_total_y,
  output logic signed [SUM_W-1:0]    accel_total_z,
  output logic        [WINDOW_W-1:0] period_samples,
  output logic        [TIME_W-1:0]   period_elapsed_us
);

  lane_ctl_t                   ctl;
  logic [LIMIT_W-1:0]          gyro_limit;
  logic [LIMIT_W-1:0]          accel_limit;
  logic [AXES-1:0][SAMPLE_W-1:0] samples;
  logic [AXES-1:0]             lane_inside;
  logic [AXES-1:0][SUM_W-1:0]  lane_sums;
  logic [AXES-1:0][SUM_W-1:0]  totals;

  // lane order: gyro x/y/z then accel x/y/z
  assign samples[0] = gyro_x;
  assign samples[1] = gyro_y;
  assign samples[2] = gyro_z;
  assign samples[3] = accel_x;
  assign samples[4] = accel_y;
  assign samples[5] = accel_z;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    isd_lane #(
      .AVERAGE_BLOCK(AVERAGE_BLOCK)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .limit     ((a < GYRO_AXES) ? gyro_limit : accel_limit),
      .sample    (samples[a]),
      .in_band   (lane_inside[a]),
      .sum_after (lane_sums[a])
    );
  end

  // merges the lane flags, keeps the period state and the result register
  isd_ctrl #(
    .AVERAGE_BLOCK(AVERAGE_BLOCK)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .now_us            (now_us),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .gyro_limit        (gyro_limit),
    .accel_limit       (accel_limit),
    .lane_inside       (lane_inside),
    .lane_sums         (lane_sums),
    .ctl               (ctl),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .is_still          (is_still),
    .period_done       (period_done),
    .totals            (totals),
    .period_samples    (period_samples),
    .period_elapsed_us (period_elapsed_us)
  );

  assign gyro_total_x  = totals[0];
  assign gyro_total_y  = totals[1];
  assign gyro_total_z  = totals[2];
  assign accel_total_x = totals[3];
  assign accel_total_y = totals[4];
  assign accel_total_z = totals[5];

endmodule

`default_nettype wire

// ===== rtl/isd_props.sv =====
// Port-level properties for the IMU stationary detector, bound to the top.
// Depends on isd_pkg and imu_stationary_detector_core.
`timescale 1ns / 1ps
`default_nettype none

module isd_props
  import isd_pkg::*;
(
  input wire                clk,
  input wire                rst,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input wire                is_still,
  input wire                period_done,
  input wire [SUM_W-1:0]    gyro_total_x,
  input wire [SUM_W-1:0]    accel_total_z,
  input wire [WINDOW_W-1:0] period_samples,
  input wire [TIME_W-1:0]   period_elapsed_us
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(period_done) && $stable(is_still)
      && $stable(period_samples) && $stable(period_elapsed_us))
    else $error("result beat changed while stalled");

  // a closed period always leaves the block stationary
  a_done_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && period_done |-> is_still)
    else $error("period closed without stationary flag");

  // period fields read zero when no period closes
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !period_done |-> gyro_total_x == '0 && accel_total_z == '0
      && period_samples == '0 && period_elapsed_us == '0)
    else $error("period fields non-zero without a closed period");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  // the input is only held back when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

endmodule

bind imu_stationary_detector_core isd_props u_props (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .is_still          (is_still),
  .period_done       (period_done),
  .gyro_total_x      (gyro_total_x),
  .accel_total_z     (accel_total_z),
  .period_samples    (period_samples),
  .period_elapsed_us (period_elapsed_us)
);

`default_nettype wire

// ===== sim/tb_imu_stationary_detector_core.sv =====
// Self-checking bench for imu_stationary_detector_core: directed plan, then random phases.
// Needs isd_pkg and the detector RTL; an in-bench motion/period predictor supplies expectations.
`timescale 1ns / 1ps

module tb_imu_stationary_detector_core;
  import isd_pkg::*;

  localparam int AVERAGE_BLOCK = 125;
  localparam int PHASE_ITEMS   = 112;     // four random phases, ~450 samples
  localparam int CYCLE_LIMIT   = 200000;  // watchdog limit on the whole run
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, must be dropped

  // one IMU sample: ax[0..2] gyro x/y/z, ax[3..5] accel x/y/z
  typedef struct packed {
    logic [AXES-1:0][SAMPLE_W-1:0] ax;
    logic [TIME_W-1:0]             now;
  } imu_beat_t;

  typedef struct packed {
    logic                       still;
    logic                       done;
    logic [AXES-1:0][SUM_W-1:0] tot;
    logic [WINDOW_W-1:0]        n;
    logic [TIME_W-1:0]          el;
  } imu_report_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    imu_beat_t            beat;
    bit                   quiet;  // expect an all-zero report, not stationary
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic [SAMPLE_W-1:0]   accel_x = '0, accel_y = '0, accel_z = '0;
  logic [TIME_W-1:0]     now_us = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  is_still, period_done;
  logic [SUM_W-1:0]      gyro_total_x, gyro_total_y, gyro_total_z;
  logic [SUM_W-1:0]      accel_total_x, accel_total_y, accel_total_z;
  logic [WINDOW_W-1:0]   period_samples;
  logic [TIME_W-1:0]     period_elapsed_us;

  imu_stationary_detector_core #(.AVERAGE_BLOCK(AVERAGE_BLOCK)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .now_us(now_us),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_still(is_still), .period_done(period_done),
    .gyro_total_x(gyro_total_x), .gyro_total_y(gyro_total_y), .gyro_total_z(gyro_total_z),
    .accel_total_x(accel_total_x), .accel_total_y(accel_total_y),
    .accel_total_z(accel_total_z),
    .period_samples(period_samples), .period_elapsed_us(period_elapsed_us)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and of the detector state.
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0]         gyro_lim, accel_lim;
  logic [WINDOW_W-1:0]        win_len;
  int                         blk_acc [AXES];
  logic signed [SAMPLE_W-1:0] blk_mean [AXES];
  int                         blk_fill;
  logic signed [SAMPLE_W-1:0] ref_axis [AXES];
  logic [SUM_W-1:0]           still_acc [AXES];
  logic [WINDOW_W-1:0]        still_n;
  logic [TIME_W-1:0]          window_t0;
  bit                         at_rest;

  imu_report_t pending_reports [$];  // one report owed per accepted sample beat
  int          mismatches = 0;
  int          cycle_count = 0;
  string       total_label [AXES] = '{"gyro_total_x", "gyro_total_y", "gyro_total_z",
                                      "accel_total_x", "accel_total_y", "accel_total_z"};

  // random stimulus shaping
  int          pose [AXES];   // where the "sensor" currently sits
  logic [31:0] sensor_us;
  int          burst_left = 0;

  // receiver stall pattern
  int stall_mode = 0;
  int stall_hold = 0;

  // Block average, band check against the reference, then either a motion
  // restart or one more still sample (possibly closing a period).
  function automatic imu_report_t predict_report(imu_beat_t b);
    imu_report_t        r;
    logic signed [15:0] s, d;
    int                 dv, lv, i;
    bit                 moving;
    r = '0;
    moving = 1'b0;
    for (i = 0; i < AXES; i++) blk_acc[i] += int'($signed(b.ax[i]));
    blk_fill++;
    if (blk_fill >= AVERAGE_BLOCK) begin
      // int division truncates toward zero, as the block mean must
      for (i = 0; i < AXES; i++) begin
        blk_mean[i] = 16'(blk_acc[i] / AVERAGE_BLOCK);
        blk_acc[i]  = 0;
      end
      blk_fill = 0;
    end
    for (i = 0; i < AXES; i++) begin
      s  = b.ax[i];
      d  = s - ref_axis[i];  // wraps to 16 bits
      dv = int'(d);
      lv = (i < GYRO_AXES) ? int'(gyro_lim) : int'(accel_lim);
      if (!(dv < lv && dv > -lv)) moving = 1'b1;
    end
    if (moving) begin
      at_rest = 1'b0;
      for (i = 0; i < AXES; i++) begin
        ref_axis[i]  = blk_mean[i];
        still_acc[i] = '0;
      end
      still_n   = '0;
      window_t0 = b.now;
      return r;
    end
    still_n++;
    for (i = 0; i < AXES; i++) still_acc[i] += {{16{b.ax[i][15]}}, b.ax[i]};
    if (still_n < win_len) begin
      r.still = at_rest;
      return r;
    end
    // window of zero behaves as one: every still sample lands here
    at_rest = 1'b1;
    r.still = 1'b1;
    r.done  = 1'b1;
    for (i = 0; i < AXES; i++) begin
      r.tot[i]     = still_acc[i];
      still_acc[i] = '0;
    end
    r.n       = still_n;
    r.el      = b.now - window_t0;
    still_n   = '0;
    window_t0 = b.now;
    return r;
  endfunction

  task automatic reset_model();
    gyro_lim  = GYRO_LIMIT_RST;
    accel_lim = ACCEL_LIMIT_RST;
    win_len   = STILL_WINDOW_RST;
    for (int i = 0; i < AXES; i++) begin
      blk_acc[i] = 0; blk_mean[i] = '0; ref_axis[i] = '0; still_acc[i] = '0; pose[i] = 0;
    end
    blk_fill  = 0;
    still_n   = '0;
    window_t0 = '0;
    at_rest   = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Every call starts and ends in the active region of a rising
  // edge; handshake signals read there still hold their pre-edge values.
  // ---------------------------------------------------------------------------

  // Hold off until every owed report has been taken; the block is then idle.
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(input imu_beat_t b, input bit quiet);
    imu_report_t want;
    int          gap;
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      // new burst; zero gaps give long unbroken runs now and then
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    gyro_x  <= b.ax[0]; gyro_y  <= b.ax[1]; gyro_z  <= b.ax[2];
    accel_x <= b.ax[3]; accel_y <= b.ax[4]; accel_z <= b.ax[5];
    now_us  <= b.now;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    want = predict_report(b);
    pending_reports.push_back(quiet ? imu_report_t'('0) : want);
  endtask

  // Register write, idle block only. cfg_valid is left high so back-to-back
  // writes need no second assignment in one step; send_sample drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_reports();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GYRO_LIMIT:   gyro_lim  = data[LIMIT_W-1:0];
      REG_ACCEL_LIMIT:  accel_lim = data[LIMIT_W-1:0];
      REG_STILL_WINDOW: win_len   = data[WINDOW_W-1:0];
      default: ;  // unmapped index is dropped
    endcase
  endtask

  // Mostly samples scattered around the current pose (so the reference
  // settles and still periods close), some on the reference, exactly on or just
  // inside the band edge, a few pure noise to toggle every bit.
  function automatic imu_beat_t next_random_sample();
    imu_beat_t b;
    int        pick, lim, span, v, i;
    pick = $urandom_range(99);
    if ($urandom_range(299) == 0)
      for (i = 0; i < AXES; i++) pose[i] = $urandom_range(40000) - 20000;
    for (i = 0; i < AXES; i++) begin
      lim  = (i < GYRO_AXES) ? int'(gyro_lim) : int'(accel_lim);
      span = lim / 3;
      if (pick < 8)
        v = $urandom;
      else if (pick < 20) begin
        v = int'(ref_axis[i]);
        if ($urandom_range(2) == 0)
          case ($urandom_range(3))
            0: v = v + lim;
            1: v = v - lim;
            2: v = v + lim - 1;
            default: v = v - lim + 1;
          endcase
      end else
        v = pose[i] + int'($urandom_range(2 * span)) - span;
      b.ax[i] = 16'(v);
    end
    sensor_us += $urandom_range(1, 3000);
    if ($urandom_range(49) == 0) sensor_us = $urandom;
    b.now = sensor_us;
    return b;
  endfunction

  function automatic plan_row_t smp(int gx, int gy, int gz, int axl, int ay, int az,
                                    logic [31:0] t, bit quiet);
    plan_row_t r;
    r.kind  = ROW_SAMPLE;
    r.beat.ax[0] = 16'(gx); r.beat.ax[1] = 16'(gy); r.beat.ax[2] = 16'(gz);
    r.beat.ax[3] = 16'(axl); r.beat.ax[4] = 16'(ay); r.beat.ax[5] = 16'(az);
    r.beat.now = t;
    r.quiet = quiet;
    r.idx   = '0;
    r.data  = '0;
    return r;
  endfunction

  function automatic plan_row_t cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r.kind  = ROW_CFG;
    r.beat  = '0;
    r.quiet = 1'b0;
    r.idx   = idx;
    r.data  = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan [$];
    logic [LIMIT_W-1:0]  g, a;
    logic [WINDOW_W-1:0] w;

    reset_model();
    sensor_us = 32'hFFF0_0000;  // timestamps start near the wrap point in the random part

    // Directed plan. Quiet rows carry their obvious answer: all-zero report,
    // not stationary. The rest go through the predictor.
    // Defaults after reset: limits 100, window 833, reference zero.
    plan.push_back(smp(0, 0, 0, 0, 0, 0, 10, 1));
    plan.push_back(smp(99, -99, 50, -50, 99, -99, 20, 1));  // just inside the band
    plan.push_back(smp(0, 0, 0, 0, 0, 100, 30, 1));         // on the edge: motion
    plan.push_back(smp(0, 0, 0, 0, -100, 0, 40, 1));
    // window zero acts as one: each still sample closes a period
    plan.push_back(cfg(REG_STILL_WINDOW, 16'd0));
    plan.push_back(smp(0, 0, 0, 0, 0, 0, 1040, 0));
    plan.push_back(smp(5, 0, 0, 0, 0, 0, 1050, 0));
    // zero limit: nothing fits strictly inside
    plan.push_back(cfg(REG_STILL_WINDOW, 16'd1));
    plan.push_back(cfg(REG_GYRO_LIMIT, 16'd0));
    plan.push_back(smp(0, 0, 0, 0, 0, 0, 2000, 1));
    // widest limits; bit 15 of the data is masked off; spare index ignored
    plan.push_back(cfg(REG_GYRO_LIMIT, 16'hFFFF));
    plan.push_back(cfg(REG_ACCEL_LIMIT, 16'h7FFF));
    plan.push_back(cfg(REG_SPARE, 16'h1234));
    plan.push_back(smp(32767, 32767, 32767, 32767, 32767, 32767, 3000, 1));
    plan.push_back(smp(-32768, -32768, -32768, -32768, -32768, -32768, 32'hFFFF_FFFF, 1));
    // largest in-band swing, period closes across the timestamp wrap
    plan.push_back(smp(32766, -32766, 32766, -32766, 32766, -32766, 5, 0));
    plan.push_back(cfg(REG_ACCEL_LIMIT, 16'd0));
    plan.push_back(smp(0, 0, 0, 0, 0, 0, 100, 1));
    // back to defaults, longest window: still but no period
    plan.push_back(cfg(REG_GYRO_LIMIT, 16'd100));
    plan.push_back(cfg(REG_ACCEL_LIMIT, 16'd100));
    plan.push_back(cfg(REG_STILL_WINDOW, 16'hFFFF));
    plan.push_back(smp(1, 0, 0, 0, 0, 0, 200, 1));
    plan.push_back(smp(0, -1, 0, 0, 0, 0, 300, 1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) write_reg(plan[k].idx, plan[k].data);
      else send_sample(plan[k].beat, plan[k].quiet);
    end

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin g = 15'd100; a = 15'd100; w = 16'($urandom_range(1, 8)); end
        1: begin g = 15'($urandom_range(1, 40)); a = 15'($urandom_range(200, 3000));
                 w = 16'($urandom_range(2, 30)); end
        2: begin g = 15'd32767; a = 15'($urandom_range(1000, 32767));
                 w = 16'($urandom_range(10, 60)); end
        default: begin g = 15'd1; a = 15'd1; w = 16'd1; end  // only samples exactly on the reference stay still
      endcase
      write_reg(REG_GYRO_LIMIT, 16'(g));
      write_reg(REG_ACCEL_LIMIT, 16'(a));
      write_reg(REG_STILL_WINDOW, w);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) drain_reports();  // full drain mid-stream
        send_sample(next_random_sample(), 1'b0);
      end
    end

    drain_reports();
    repeat (8) @(posedge clk);  // catch any stray beat after the last report
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall modes of random length - never, about half, mostly.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(2);
      stall_hold = $urandom_range(20, 120);
    end
    stall_hold--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(1) == 1);
      default: out_stall <= ($urandom_range(7) != 0);
    endcase
  end

  // Result check, field by field, against the oldest owed report.
  always @(posedge clk) begin
    imu_report_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.still = is_still;
      got.done  = period_done;
      got.tot[0] = gyro_total_x;  got.tot[1] = gyro_total_y;  got.tot[2] = gyro_total_z;
      got.tot[3] = accel_total_x; got.tot[4] = accel_total_y; got.tot[5] = accel_total_z;
      got.n  = period_samples;
      got.el = period_elapsed_us;
      if (pending_reports.size() == 0) begin
        $error("result beat with no report owed");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (got.still !== want.still) begin
          $error("is_still: expected %0d, got %0d", want.still, got.still);
          mismatches++;
        end
        if (got.done !== want.done) begin
          $error("period_done: expected %0d, got %0d", want.done, got.done);
          mismatches++;
        end
        for (int i = 0; i < AXES; i++)
          if (got.tot[i] !== want.tot[i]) begin
            $error("%s: expected %0d, got %0d", total_label[i],
                   $signed(want.tot[i]), $signed(got.tot[i]));
            mismatches++;
          end
        if (got.n !== want.n) begin
          $error("period_samples: expected %0d, got %0d", want.n, got.n);
          mismatches++;
        end
        if (got.el !== want.el) begin
          $error("period_elapsed_us: expected %0d, got %0d", want.el, got.el);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
